// File: src/icc_pkg.sv
// shared types, constants and helpers of the 3x3 convolution filter
`default_nettype none

package icc_pkg;

	// default frame limits
	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	// pixel and kernel geometry
	localparam int PIX_W   = 8;
	localparam int NUM_CH  = 3;
	localparam int TAPS    = 9;
	localparam int COEF_W  = 16;
	localparam int KROW_W  = 48;
	localparam int DIM_W   = 12;
	localparam int COORD_W = 11;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd5;

	// register reset values
	localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 48'd0;
	localparam logic [KROW_W-1:0] KERNEL_MID_RST    = 48'd256;
	localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 48'd0;
	localparam logic [DIM_W-1:0]  WIDTH_RST         = 12'd640;
	localparam logic [DIM_W-1:0]  HEIGHT_RST        = 12'd480;

	// one pixel, channel 0 in the low byte
	typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;

	// 3x3 neighborhood, tap row*3+col
	typedef pix_t [TAPS-1:0] window_t;

	// three kernel rows
	typedef logic [2:0][KROW_W-1:0] kernel_t;

	// position and framing of a result word
	typedef struct packed {
		logic [COORD_W-1:0] center_row;
		logic [COORD_W-1:0] center_col;
		logic               frame_last;
	} res_meta_t;

	// width of the effective size values and of their compares
	function automatic int eff_dim_w(int max_v);
		int cw;
		cw = $clog2(max_v) + 1;
		return (cw > DIM_W) ? cw : DIM_W;
	endfunction

endpackage

`default_nettype wire

// File: src/icc_ifs.sv
// valid/ready channel interfaces of the convolution filter
`default_nettype none

interface icc_pix_if;
	import icc_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pix_chan0;
	logic [PIX_W-1:0] pix_chan1;
	logic [PIX_W-1:0] pix_chan2;

	modport source (output valid, pix_chan0, pix_chan1, pix_chan2, input ready);
	modport sink (input valid, pix_chan0, pix_chan1, pix_chan2, output ready);
endinterface

interface icc_res_if;
	import icc_pkg::*;
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   out_chan0;
	logic [PIX_W-1:0]   out_chan1;
	logic [PIX_W-1:0]   out_chan2;
	logic [COORD_W-1:0] center_row;
	logic [COORD_W-1:0] center_col;
	logic               frame_last;

	modport source (output valid, out_chan0, out_chan1, out_chan2, center_row, center_col,
		frame_last, input ready);
	modport sink (input valid, out_chan0, out_chan1, out_chan2, center_row, center_col,
		frame_last, output ready);
endinterface

interface icc_cfg_if;
	import icc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/icc_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module icc_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/icc_cfg.sv
// configuration registers and effective frame size
`default_nettype none

module icc_cfg #(
	parameter int MAX_WIDTH  = icc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = icc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          wr_en,
	input  wire logic [icc_pkg::CFG_IDX_W-1:0]                 wr_idx,
	input  wire logic [icc_pkg::CFG_DATA_W-1:0]                wr_data,
	output icc_pkg::kernel_t                                   kernel,
	output logic                                               color_mode,
	output logic [icc_pkg::eff_dim_w(MAX_WIDTH)-1:0]           w_eff,
	output logic [icc_pkg::eff_dim_w(MAX_HEIGHT)-1:0]          h_eff
);
	import icc_pkg::*;

	localparam int EW = eff_dim_w(MAX_WIDTH);
	localparam int EH = eff_dim_w(MAX_HEIGHT);

	kernel_t          kernel_q;
	logic             mode_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q[0] <= KERNEL_TOP_RST;
			kernel_q[1] <= KERNEL_MID_RST;
			kernel_q[2] <= KERNEL_BOTTOM_RST;
			mode_q      <= 1'b0;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_KERNEL_TOP:    kernel_q[0] <= wr_data[KROW_W-1:0];
				REG_KERNEL_MID:    kernel_q[1] <= wr_data[KROW_W-1:0];
				REG_KERNEL_BOTTOM: kernel_q[2] <= wr_data[KROW_W-1:0];
				REG_COLOR_MODE:    mode_q      <= wr_data[0];
				REG_IMAGE_WIDTH:   width_q     <= wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  height_q    <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// zero counts as one, oversize saturates to the buffer limit
	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(width_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = EH'(1);
		end else if (EH'(height_q) > EH'(MAX_HEIGHT)) begin
			h_eff = EH'(MAX_HEIGHT);
		end else begin
			h_eff = EH'(height_q);
		end
	end

	assign kernel     = kernel_q;
	assign color_mode = mode_q;

endmodule

`default_nettype wire

// File: src/icc_front.sv
// raster counters, line buffers and the 3x3 window
`default_nettype none

module icc_front #(
	parameter int MAX_WIDTH  = icc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = icc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire icc_pkg::pix_t                        in_pix,
	input  wire logic [icc_pkg::eff_dim_w(MAX_WIDTH)-1:0]  w_eff,
	input  wire logic [icc_pkg::eff_dim_w(MAX_HEIGHT)-1:0] h_eff,
	output logic                                      win_valid,
	input  wire logic                                 win_ready,
	output icc_pkg::window_t                          win,
	output icc_pkg::res_meta_t                        meta
);
	import icc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int EW = eff_dim_w(MAX_WIDTH);
	localparam int EH = eff_dim_w(MAX_HEIGHT);
	localparam int LB_W = $bits(pix_t);

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          accept;
	logic          last_col;
	logic          last_row;

	logic          valid_s1;
	pix_t          pix_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1;
	res_meta_t     meta_s1;

	logic          fwd_q;
	pix_t          fwd_up_q;
	pix_t          fwd_lo_q;

	pix_t          up_rd;
	pix_t          lo_rd;
	pix_t          up_eff;
	pix_t          lo_eff;

	window_t       win_q;
	logic          win_valid_q;
	res_meta_t     meta_s2;

	logic          s2_free;
	logic          s1_move;

	// handshake across the stages
	assign s2_free  = !win_valid_q || win_ready;
	assign s1_move  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	// end of row and end of frame
	assign last_col = (EW'(col_q) + EW'(1)) >= w_eff;
	assign last_row = (EH'(row_q) + EH'(1)) >= h_eff;

	// raster position of the next word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line buffers: upper holds two rows back, lower one row back
	icc_ram #(
		.DATA_W (LB_W),
		.DEPTH  (MAX_WIDTH)
	) u_lb_upper (
		.clk   (clk),
		.we    (s1_move),
		.waddr (col_s1),
		.wdata (lo_eff),
		.re    (accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	icc_ram #(
		.DATA_W (LB_W),
		.DEPTH  (MAX_WIDTH)
	) u_lb_lower (
		.clk   (clk),
		.we    (s1_move),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (col_q),
		.rdata (lo_rd)
	);

	// same-column write in the read cycle (one-pixel rows) bypasses the ram
	assign up_eff = fwd_q ? fwd_up_q : up_rd;
	assign lo_eff = fwd_q ? fwd_lo_q : lo_rd;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload and bypass capture
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1             <= in_pix;
			col_s1             <= col_q;
			emit_s1            <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			meta_s1.center_row <= COORD_W'(row_q - RW'(1));
			meta_s1.center_col <= COORD_W'(col_q - CW'(1));
			meta_s1.frame_last <= last_row && last_col;
			fwd_q              <= s1_move && (col_s1 == col_q);
			fwd_up_q           <= lo_eff;
			fwd_lo_q           <= pix_s1;
		end
	end

	// window shift, new column from the buffers and the incoming word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_move) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= up_eff;
			win_q[5] <= lo_eff;
			win_q[8] <= pix_s1;
		end
	end

	// window holds a result for the filter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_valid_q <= 1'b0;
		end else if (s2_free) begin
			win_valid_q <= s1_move && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			meta_s2 <= meta_s1;
		end
	end

	assign win_valid = win_valid_q;
	assign win       = win_q;
	assign meta      = meta_s2;

	// window must not move under a pending result
	a_win_hold: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid_q && !win_ready |=> $stable(win_q))
		else $error("window changed while its result was stalled");

	// row end wraps the column
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_col |=> col_q == '0)
		else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire

// File: src/icc_filter.sv
// per-channel kernel products, sum, clamp and result register
`default_nettype none

module icc_filter (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   win_valid,
	output logic                                        win_ready,
	input  wire icc_pkg::window_t                       win,
	input  wire icc_pkg::res_meta_t                     meta,
	input  wire icc_pkg::kernel_t                       kernel,
	input  wire logic                                   color_mode,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output icc_pkg::pix_t                               out_pix,
	output icc_pkg::res_meta_t                          out_meta
);
	import icc_pkg::*;

	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int SUM_W  = PROD_W + 4;

	logic [NUM_CH-1:0][TAPS-1:0][PROD_W-1:0] prod;
	logic [NUM_CH-1:0][TAPS-1:0][PROD_W-1:0] prod_s3;
	logic                                    valid_s3;
	res_meta_t                               meta_s3;

	logic signed [SUM_W-1:0]                 sum [NUM_CH];
	pix_t                                    clamped;

	logic                                    out_valid_q;
	pix_t                                    out_pix_q;
	res_meta_t                               meta_out_q;

	logic                                    out_free;
	logic                                    s3_load;

	assign out_free  = !out_valid_q || out_ready;
	assign win_ready = !valid_s3 || out_free;
	assign s3_load   = win_ready;

	// coefficient times sample, one product per tap and channel
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			for (int t = 0; t < TAPS; t++) begin
				prod[ch][t] = PROD_W'(
					signed'(kernel[t/3][(t%3)*COEF_W +: COEF_W]) *
					signed'({1'b0, win[t][ch]}));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_load) begin
			valid_s3 <= win_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_load && win_valid) begin
			prod_s3 <= prod;
			meta_s3 <= meta;
		end
	end

	// nine-term sum, negative to zero, floor by 256, saturate
	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum[ch] = '0;
			for (int t = 0; t < TAPS; t++) begin
				sum[ch] = sum[ch] + SUM_W'(signed'(prod_s3[ch][t]));
			end
			if (sum[ch][SUM_W-1]) begin
				clamped[ch] = '0;
			end else if (|sum[ch][SUM_W-2:16]) begin
				clamped[ch] = '1;
			end else begin
				clamped[ch] = sum[ch][15:8];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s3) begin
			out_pix_q[0] <= clamped[0];
			out_pix_q[1] <= color_mode ? clamped[1] : '0;
			out_pix_q[2] <= color_mode ? clamped[2] : '0;
			meta_out_q   <= meta_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_meta  = meta_out_q;

	// products stay put while the result register is blocked
	a_prod_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_free |=> valid_s3 && $stable(prod_s3))
		else $error("product stage lost or changed a stalled word");

	// a window taken always lands in the product stage
	a_win_take: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid && win_ready |=> valid_s3)
		else $error("accepted window did not reach the product stage");

endmodule

`default_nettype wire

// File: src/image_conv3x3_clamp.sv
// top level of the streaming 3x3 convolution filter with clamp
//
// channel  dir  payload                                           accepted when
// cfg      in   index, data (kernel rows, mode, width, height)    valid && ready
// pix      in   pix_chan0..2                                      valid && ready
// res      out  out_chan0..2, center_row, center_col, frame_last  valid && ready
//
// one pixel word per clock unless res stalls; stages s1, window, product, result
// the line-buffer ram ports (one read, one write per clock) set the pixel rate
// border pixels give no result word; the raster position runs on
// reset clears counters, window, registers and valids; buffers fill as rows pass
// a stalled result holds the pipe back stage by stage, bubbles are squeezed out
`default_nettype none

module image_conv3x3_clamp #(
	parameter int MAX_WIDTH  = icc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = icc_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	icc_cfg_if.sink     cfg,
	icc_pix_if.sink     pix,
	icc_res_if.source   res
);
	import icc_pkg::*;

	localparam int EW = eff_dim_w(MAX_WIDTH);
	localparam int EH = eff_dim_w(MAX_HEIGHT);

	kernel_t          kernel;
	logic             color_mode;
	logic [EW-1:0]    w_eff;
	logic [EH-1:0]    h_eff;

	pix_t             in_pix;
	logic             win_valid;
	logic             win_ready;
	window_t          win;
	res_meta_t        meta;
	pix_t             out_pix;
	res_meta_t        out_meta;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	icc_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg.valid),
		.wr_idx     (cfg.index),
		.wr_data    (cfg.data),
		.kernel     (kernel),
		.color_mode (color_mode),
		.w_eff      (w_eff),
		.h_eff      (h_eff)
	);

	// input word packing
	assign in_pix[0] = pix.pix_chan0;
	assign in_pix[1] = pix.pix_chan1;
	assign in_pix[2] = pix.pix_chan2;

	icc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.in_pix    (in_pix),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win       (win),
		.meta      (meta)
	);

	icc_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.win_valid  (win_valid),
		.win_ready  (win_ready),
		.win        (win),
		.meta       (meta),
		.kernel     (kernel),
		.color_mode (color_mode),
		.out_valid  (res.valid),
		.out_ready  (res.ready),
		.out_pix    (out_pix),
		.out_meta   (out_meta)
	);

	// result word unpacking
	assign res.out_chan0  = out_pix[0];
	assign res.out_chan1  = out_pix[1];
	assign res.out_chan2  = out_pix[2];
	assign res.center_row = out_meta.center_row;
	assign res.center_col = out_meta.center_col;
	assign res.frame_last = out_meta.frame_last;

endmodule

`default_nettype wire
